// ----- sv/osc_pkg.sv -----
// ----------------------------------------------------------------------------
// osc_pkg
// Shared constants and types for the opcode signature checksum core.
// ----------------------------------------------------------------------------
`default_nettype none

package osc_pkg;

   localparam int unsigned WORD_W    = 32;
   localparam int unsigned OPCODE_W  = 6;
   localparam int unsigned SIG_ROT   = 17;

   localparam logic [WORD_W-1:0] PRIMARY_MASK = 32'hFC00_0000;
   localparam logic [WORD_W-1:0] LOW6_MASK    = 32'h0000_003F;
   localparam logic [WORD_W-1:0] MID5_MASK    = 32'h0000_07C0;
   localparam logic [WORD_W-1:0] IMM_MASK     = 32'h03FF_0000;
   localparam logic [WORD_W-1:0] EXT_MASK     = 32'h0000_07FF;

   // Primary opcodes that select a sub-opcode class.
   localparam logic [OPCODE_W-1:0] OP_PAIRED   = 6'd4;
   localparam logic [OPCODE_W-1:0] OP_IMM_A    = 6'd7;
   localparam logic [OPCODE_W-1:0] OP_IMM_B    = 6'd8;
   localparam logic [OPCODE_W-1:0] OP_IMM_LO   = 6'd10;
   localparam logic [OPCODE_W-1:0] OP_IMM_HI   = 6'd15;
   localparam logic [OPCODE_W-1:0] OP_EXT_19   = 6'd19;
   localparam logic [OPCODE_W-1:0] OP_EXT_31   = 6'd31;
   localparam logic [OPCODE_W-1:0] OP_EXT_63   = 6'd63;
   localparam logic [OPCODE_W-1:0] OP_FLOAT    = 6'd59;
   localparam logic [OPCODE_W-1:0] OP_LDST_LO  = 6'd32;
   localparam logic [OPCODE_W-1:0] OP_LDST_HI  = 6'd55;

   // Paired-single low-field codes that also carry the middle field.
   localparam logic [OPCODE_W-1:0] PS_LOW_0    = 6'd0;
   localparam logic [OPCODE_W-1:0] PS_LOW_8    = 6'd8;
   localparam logic [OPCODE_W-1:0] PS_LOW_16   = 6'd16;
   localparam logic [OPCODE_W-1:0] PS_LOW_21   = 6'd21;
   localparam logic [OPCODE_W-1:0] PS_LOW_22   = 6'd22;
   localparam logic [OPCODE_W-1:0] FLT_LOW_LIM = 6'd16;

   // Control of the word held in the input register.
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } stage_ctl_type;

endpackage : osc_pkg

`default_nettype wire

// ----- sv/opcode_signature_checksum_core.sv -----
// ----------------------------------------------------------------------------
// opcode_signature_checksum_core
// Rotate-xor signature over the opcode bits of a function's instruction words.
// ----------------------------------------------------------------------------
// An accepted last word passes the input register, then the result register.
// Throughput: one item per cycle, but a last word waits while a result is held.
// Input register -> opcode reduction -> rotate-xor -> signature and result.
// Reset: synchronous, active high; clears the running signature to zero and
// drops both valid flags.
`default_nettype none

module opcode_signature_checksum_core
   import osc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [WORD_W-1:0] req_tdata,   // [31:0] instr_word
   input  wire logic              req_tuser,   // [0] first_word
   input  wire logic              req_tlast,   // last_word
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic      [WORD_W-1:0] rsp_tdata    // [31:0] signature
);

   stage_ctl_type     ctl_ff, ctl_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic [WORD_W-1:0] reduced;
   logic              advance;

   // The input register refills in the same cycle it hands its item on.
   assign req_tready = !ctl_ff.valid || advance;

   always_comb begin
      ctl_in  = ctl_ff;
      word_in = word_ff;
      if (advance) begin
         ctl_in.valid = 1'b0;
      end
      if (req_tvalid && req_tready) begin
         ctl_in.valid = 1'b1;
         ctl_in.first = req_tuser;
         ctl_in.last  = req_tlast;
         word_in      = req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff.valid <= ctl_in.valid;
      end
      ctl_ff.first <= ctl_in.first;
      ctl_ff.last  <= ctl_in.last;
      word_ff      <= word_in;
   end

   osc_reduce u_reduce (
      .word    (word_ff),
      .reduced (reduced)
   );

   osc_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .stage_ctl  (ctl_ff),
      .reduced    (reduced),
      .advance    (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule : opcode_signature_checksum_core

`default_nettype wire

// ----- sv/osc_reduce.sv -----
// ----------------------------------------------------------------------------
// osc_reduce
// Reduces one instruction word to its primary opcode and sub-opcode bits.
// ----------------------------------------------------------------------------
`default_nettype none

module osc_reduce
   import osc_pkg::*;
(
   input  wire logic [WORD_W-1:0] word,
   output logic      [WORD_W-1:0] reduced
);

   logic [OPCODE_W-1:0] primary;
   logic [OPCODE_W-1:0] low;
   logic [WORD_W-1:0]   sub;

   assign primary = word[WORD_W-1 -: OPCODE_W];
   assign low     = word[OPCODE_W-1:0];

   always_comb begin
      sub = '0;
      unique case (primary) inside
         OP_PAIRED: begin
            sub = word & LOW6_MASK;
            if (low == PS_LOW_0 || low == PS_LOW_8 || low == PS_LOW_16 ||
                low == PS_LOW_21 || low == PS_LOW_22) begin
               sub = sub | (word & MID5_MASK);
            end
         end
         OP_IMM_A, OP_IMM_B, [OP_IMM_LO:OP_IMM_HI], [OP_LDST_LO:OP_LDST_HI]: begin
            sub = word & IMM_MASK;
         end
         OP_EXT_19, OP_EXT_31, OP_EXT_63: begin
            sub = word & EXT_MASK;
         end
         OP_FLOAT: begin
            sub = word & LOW6_MASK;
            if (low < FLT_LOW_LIM) begin
               sub = sub | (word & MID5_MASK);
            end
         end
         default: begin
            sub = '0;
         end
      endcase
   end

   assign reduced = (word & PRIMARY_MASK) | sub;

endmodule : osc_reduce

`default_nettype wire

// ----- sv/osc_accum.sv -----
// ----------------------------------------------------------------------------
// osc_accum
// Running rotate-xor signature and the result register toward the output.
// ----------------------------------------------------------------------------
`default_nettype none

module osc_accum
   import osc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire stage_ctl_type       stage_ctl,
   input  wire logic [WORD_W-1:0]   reduced,
   output logic                     advance,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic      [WORD_W-1:0]   rsp_tdata
);

   logic [WORD_W-1:0] sum_ff, sum_in;
   logic [WORD_W-1:0] base;
   logic [WORD_W-1:0] next_sum;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_data_ff, rsp_data_in;
   logic              out_free;

   // The result register may take a new item when it is empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign advance  = stage_ctl.valid && (!stage_ctl.last || out_free);

   assign base     = stage_ctl.first ? '0 : sum_ff;
   assign next_sum = {base[WORD_W-SIG_ROT-1:0], base[WORD_W-1:WORD_W-SIG_ROT]} ^ reduced;

   always_comb begin
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         sum_in = next_sum;
         if (stage_ctl.last) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = next_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule : osc_accum

`default_nettype wire

// ----- test/tb_opcode_signature_checksum_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_opcode_signature_checksum_core
// Streams instruction words through the signature core and checks each emitted
// signature against a rotate-xor predictor of opcode bits. A short table of
// corner cases comes first, followed by randomized functions, with bursty input
// and an irregular output stall pattern.
// ----------------------------------------------------------------------------

module tb_opcode_signature_checksum_core
   import osc_pkg::*;
;

   localparam int ITEM_TARGET  = 1050;
   localparam int DIR_COUNT    = 24;
   localparam int LONG_HOLD    = 250;
   localparam int DRAIN_CYCLES = 12;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int PRINT_LIMIT  = 40;

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              first;
      logic              last;
      logic              sig_known;
      logic [WORD_W-1:0] sig_value;
   } word_case_type;

   typedef enum int {RX_OPEN, RX_CHOPPY, RX_SPARSE, RX_BLOCKED} stall_mode_type;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [WORD_W-1:0] req_tdata  = '0;   // [31:0] instr_word
   logic              req_tuser  = 1'b0; // [0] first_word
   logic              req_tlast  = 1'b0; // last_word
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [WORD_W-1:0] rsp_tdata;         // [31:0] signature

   // Literal expectation that travels with the item on the bus, if any.
   logic              row_sig_known = 1'b0;
   logic [WORD_W-1:0] row_sig_value = '0;

   logic [WORD_W-1:0] expected_signatures[$];
   logic [WORD_W-1:0] running_signature = '0;
   int                words_accepted = 0;
   int                error_count    = 0;
   int                cycle_count    = 0;
   int                burst_left     = 0;

   word_case_type     directed_words [DIR_COUNT];

   opcode_signature_checksum_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Primary opcode plus the sub-opcode bits that its class keeps.
   function automatic logic [WORD_W-1:0] opcode_bits(input logic [WORD_W-1:0] w);
      logic [OPCODE_W-1:0] p;
      logic [OPCODE_W-1:0] low;
      logic [WORD_W-1:0]   sub;
      p   = w[WORD_W-1 -: OPCODE_W];
      low = w[OPCODE_W-1:0];
      sub = '0;
      if (p == OP_PAIRED) begin
         sub = w & LOW6_MASK;
         if (low == PS_LOW_0 || low == PS_LOW_8 || low == PS_LOW_16 ||
             low == PS_LOW_21 || low == PS_LOW_22) begin
            sub = sub | (w & MID5_MASK);
         end
      end else if (p == OP_IMM_A || p == OP_IMM_B || (p >= OP_IMM_LO && p <= OP_IMM_HI)) begin
         sub = w & IMM_MASK;
      end else if (p == OP_EXT_19 || p == OP_EXT_31 || p == OP_EXT_63) begin
         sub = w & EXT_MASK;
      end else if (p == OP_FLOAT) begin
         sub = w & LOW6_MASK;
         if (low < FLT_LOW_LIM) begin
            sub = sub | (w & MID5_MASK);
         end
      end else if (p >= OP_LDST_LO && p <= OP_LDST_HI) begin
         sub = w & IMM_MASK;
      end
      return (w & PRIMARY_MASK) | sub;
   endfunction

   function automatic logic [WORD_W-1:0] fold_signature(input logic [WORD_W-1:0] sig,
                                                        input logic [WORD_W-1:0] w);
      return ((sig << SIG_ROT) | (sig >> (WORD_W - SIG_ROT))) ^ opcode_bits(w);
   endfunction

   // Mostly opcodes from the classes that keep sub-opcode bits.
   function automatic logic [WORD_W-1:0] random_instr_word();
      logic [OPCODE_W-1:0] p;
      logic [WORD_W-1:0]   w;
      w = $urandom();
      case ($urandom_range(0, 9))
         0:       p = OP_PAIRED;
         1:       p = $urandom_range(0, 3) == 0 ? OP_IMM_A :
                      $urandom_range(0, 2) == 0 ? OP_IMM_B :
                      OPCODE_W'($urandom_range(OP_IMM_LO, OP_IMM_HI));
         2:       p = $urandom_range(0, 2) == 0 ? OP_EXT_19 :
                      $urandom_range(0, 1) == 0 ? OP_EXT_31 : OP_EXT_63;
         3:       p = OP_FLOAT;
         4:       p = OPCODE_W'($urandom_range(OP_LDST_LO, OP_LDST_HI));
         default: p = OPCODE_W'($urandom_range(0, 63));
      endcase
      w[WORD_W-1 -: OPCODE_W] = p;
      if ((p == OP_PAIRED || p == OP_FLOAT) && $urandom_range(0, 1) == 1) begin
         case ($urandom_range(0, 6))
            0:       w[OPCODE_W-1:0] = PS_LOW_0;
            1:       w[OPCODE_W-1:0] = PS_LOW_8;
            2:       w[OPCODE_W-1:0] = PS_LOW_16;
            3:       w[OPCODE_W-1:0] = PS_LOW_21;
            4:       w[OPCODE_W-1:0] = PS_LOW_22;
            5:       w[OPCODE_W-1:0] = FLT_LOW_LIM - 6'd1;
            default: w[OPCODE_W-1:0] = FLT_LOW_LIM;
         endcase
      end
      return w;
   endfunction

   task automatic send_word(input logic [WORD_W-1:0] word, input logic first,
                            input logic last, input logic sig_known,
                            input logic [WORD_W-1:0] sig_value);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
         repeat (gap) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            req_tdata  <= $urandom();
         end
         burst_left = $urandom_range(1, 32);
      end
      burst_left = burst_left - 1;
      @(negedge clock);
      req_tvalid    <= 1'b1;
      req_tdata     <= word;
      req_tuser     <= first;
      req_tlast     <= last;
      row_sig_known <= sig_known;
      row_sig_value <= sig_value;
      do @(posedge clock); while (!req_tready);
   endtask

   // Predictor and checker, both sampled on the rising edge.
   always @(posedge clock) begin : track_signature
      logic [WORD_W-1:0] sig_next;
      logic [WORD_W-1:0] sig_expected;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            sig_next          = fold_signature(req_tuser ? '0 : running_signature, req_tdata);
            running_signature = sig_next;
            words_accepted    = words_accepted + 1;
            if (req_tlast) begin
               expected_signatures.push_back(row_sig_known ? row_sig_value : sig_next);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_signatures.size() == 0) begin
               if (error_count < PRINT_LIMIT)
                  $display("%0t: unexpected signature, expected none, actual %08h",
                           $time, rsp_tdata);
               error_count = error_count + 1;
            end else begin
               sig_expected = expected_signatures.pop_front();
               if (rsp_tdata !== sig_expected) begin
                  if (error_count < PRINT_LIMIT)
                     $display("%0t: signature mismatch, expected %08h, actual %08h",
                              $time, sig_expected, rsp_tdata);
                  error_count = error_count + 1;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Output side: runs of different stall densities, and one long hold-off
   // so that the core fills up and pushes back on its input.
   initial begin : drive_rsp_ready
      stall_mode_type mode;
      int             run_len;
      bit             held_long;
      held_long = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         if (!held_long && words_accepted >= 400) begin
            held_long = 1'b1;
            repeat (LONG_HOLD) begin
               @(negedge clock);
               rsp_tready <= 1'b0;
            end
         end else begin
            mode    = stall_mode_type'($urandom_range(0, 3));
            run_len = $urandom_range(8, 48);
            repeat (run_len) begin
               @(negedge clock);
               case (mode)
                  RX_OPEN:    rsp_tready <= 1'b1;
                  RX_CHOPPY:  rsp_tready <= 1'($urandom_range(0, 1));
                  RX_SPARSE:  rsp_tready <= ($urandom_range(0, 3) != 0);
                  RX_BLOCKED: rsp_tready <= ($urandom_range(0, 4) == 0);
               endcase
            end
         end
      end
   end

   initial begin : drive_req
      int words_sent;
      int func_len;
      int i;
      directed_words = '{
         // Nothing combined since reset, and a zero word leaves zero.
         '{32'h0000_0000, 1'b0, 1'b1, 1'b1, 32'h0000_0000},
         '{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 32'hFC00_07FF},
         '{32'h0000_0000, 1'b1, 1'b1, 1'b1, 32'h0000_0000},
         '{32'h13FF_FFC0, 1'b1, 1'b1, 1'b1, 32'h1000_07C0},
         // Paired-single words whose low field does or does not keep the middle field.
         '{32'h13FF_FFC8, 1'b1, 1'b0, 1'b0, 32'h0},
         '{32'h13FF_FFD0, 1'b0, 1'b0, 1'b0, 32'h0},
         '{32'h13FF_FFD5, 1'b0, 1'b0, 1'b0, 32'h0},
         '{32'h13FF_FFD6, 1'b0, 1'b0, 1'b0, 32'h0},
         '{32'h13FF_FFFF, 1'b0, 1'b1, 1'b0, 32'h0},
         // Continues the previous signature: no first word after a last word.
         '{32'h13FF_FFC1, 1'b0, 1'b1, 1'b0, 32'h0},
         '{32'h1FFF_FFFF, 1'b1, 1'b0, 1'b0, 32'h0},
         '{32'h23FF_FFFF, 1'b0, 1'b0, 1'b0, 32'h0},
         '{32'h2BFF_FFFF, 1'b0, 1'b0, 1'b0, 32'h0},
         '{32'h3FFF_FFFF, 1'b0, 1'b1, 1'b0, 32'h0},
         '{32'h27FF_FFFF, 1'b1, 1'b1, 1'b1, 32'h2400_0000},
         '{32'h4FFF_FFFF, 1'b1, 1'b0, 1'b0, 32'h0},
         '{32'h7FFF_FFFF, 1'b0, 1'b1, 1'b0, 32'h0},
         // Float class on both sides of the low-field limit.
         '{32'hEFFF_FFCF, 1'b1, 1'b0, 1'b0, 32'h0},
         '{32'hEFFF_FFD0, 1'b0, 1'b1, 1'b0, 32'h0},
         '{32'h83FF_FFFF, 1'b1, 1'b0, 1'b0, 32'h0},
         '{32'hDFFF_FFFF, 1'b0, 1'b0, 1'b0, 32'h0},
         '{32'hE3FF_FFFF, 1'b0, 1'b1, 1'b0, 32'h0},
         '{32'hE3FF_FFFF, 1'b1, 1'b1, 1'b1, 32'hE000_0000},
         '{32'h03FF_FFFF, 1'b1, 1'b1, 1'b1, 32'h0000_0000}
      };
      words_sent = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIR_COUNT; i++) begin
         send_word(directed_words[i].word, directed_words[i].first, directed_words[i].last,
                   directed_words[i].sig_known, directed_words[i].sig_value);
         words_sent = words_sent + 1;
      end

      while (words_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 9) == 0) begin
            // Loose word with arbitrary framing flags.
            send_word(random_instr_word(), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'b0, '0);
            words_sent = words_sent + 1;
         end else begin
            func_len = $urandom_range(0, 7) == 0 ? $urandom_range(13, 40)
                                                 : $urandom_range(1, 12);
            for (i = 0; i < func_len; i++) begin
               send_word(random_instr_word(), i == 0, i == func_len - 1, 1'b0, '0);
               words_sent = words_sent + 1;
            end
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_signatures.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_signatures.size() != 0) begin
         $display("%0t: signatures missing, expected %0d more, actual none",
                  $time, expected_signatures.size());
         error_count = error_count + 1;
      end
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/osc_pkg.sv
sv/osc_reduce.sv
sv/osc_accum.sv
sv/opcode_signature_checksum_core.sv
test/tb_opcode_signature_checksum_core.sv
